/* hw/rtl/pooled_doubly_linked_list_defines.svh */
// Assertion macros for the pooled doubly linked list.
// Used by the checker; depends on nothing else.
`ifndef POOLED_DOUBLY_LINKED_LIST_DEFINES_SVH
`define POOLED_DOUBLY_LINKED_LIST_DEFINES_SVH

// Property checked at every rising clock edge, including during reset.
`define PDLL_ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pooled list property failed");

// Property checked only while out of reset.
`define PDLL_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pooled list property failed");

`endif

/* hw/rtl/pdll_pkg.sv */
// Shared constants and codes for the pooled doubly linked list.
// Depends on nothing; pdll_if, pdll_node_mem, the top level and pdll_chk use it.
`default_nettype none

package pdll_pkg;

    localparam int POOL_NODES_DEF = 128;
    localparam int VALUE_W        = 32;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int SLOT_OUT_W     = 7;
    localparam int HEAD_SLOT      = 0;
    localparam int TAIL_SLOT      = 1;
    localparam int ALLOC_RESET    = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_HEAD = 2'd0,
        MODE_INS_TAIL = 2'd1,
        MODE_DELETE   = 2'd2,
        MODE_SEARCH   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FOUND     = 2'd3
    } t_status;

endpackage

`default_nettype wire

/* hw/rtl/pdll_if.sv */
// Request and response channel interfaces of the pooled doubly linked list.
// Depends on pdll_pkg for field widths.
`default_nettype none

interface pdll_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [pdll_pkg::MODE_W-1:0]          mode;
    logic signed [pdll_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface pdll_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [pdll_pkg::STATUS_W-1:0]     status;
    logic [pdll_pkg::SLOT_OUT_W-1:0]   node_slot;

    modport source (output valid, output status, output node_slot, input ready);
    modport sink   (input valid, input status, input node_slot, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pdll_ram.sv */
// Simple dual-port synchronous memory with registered read data.
// Holds the backward links; depends on nothing.
`default_nettype none

module pdll_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 128,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/pdll_node_mem.sv */
// Node memory: value and forward link lanes behind one address pair.
// Each lane has its own write enable; depends on pdll_pkg.
`default_nettype none

module pdll_node_mem #(
    parameter int  DEPTH = pdll_pkg::POOL_NODES_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                                i_clk,
    input  logic                                i_we_value,
    input  logic                                i_we_next,
    input  logic [AW-1:0]                       i_waddr,
    input  logic signed [pdll_pkg::VALUE_W-1:0] i_wvalue,
    input  logic [AW-1:0]                       i_wnext,
    input  logic [AW-1:0]                       i_raddr,
    output logic signed [pdll_pkg::VALUE_W-1:0] o_rvalue,
    output logic [AW-1:0]                       o_rnext
);
    import pdll_pkg::*;

    logic signed [VALUE_W-1:0] value_mem [DEPTH];
    logic [AW-1:0]             next_mem  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we_value) begin
            value_mem[i_waddr] <= i_wvalue;
        end
        if (i_we_next) begin
            next_mem[i_waddr] <= i_wnext;
        end
        o_rvalue <= value_mem[i_raddr];
        o_rnext  <= next_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/pooled_doubly_linked_list.sv */
// Top level of the pooled doubly linked list: sequencer, sentinel links and
// result register. Depends on pdll_pkg, pdll_if, pdll_node_mem and pdll_ram.
//
//   channel  direction  handshake      word
//   i_req    in         valid/ready    mode, value
//   o_rsp    out        valid/ready    status, node_slot
//
// An insert passes through S_FIX and then S_PUSH; a pool-full insert, or a
// search or delete on an empty list, goes from acceptance straight to S_PUSH.
// A search or delete walks from the head, reading one node per cycle, and
// visits at most POOL_NODES - 2 nodes; the next request is taken in the
// cycle after the result loads. Synchronous reset sets up the sentinels.
// A request is taken while a result still waits; a stalled output holds.
`default_nettype none

module pooled_doubly_linked_list #(
    parameter int POOL_NODES = pdll_pkg::POOL_NODES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pdll_req_if.sink   i_req,
    pdll_rsp_if.source o_rsp
);
    import pdll_pkg::*;

    localparam int SW   = $clog2(POOL_NODES);
    localparam int AC_W = $clog2(POOL_NODES + 1);
    localparam logic [SW-1:0]   HEAD       = SW'(HEAD_SLOT);
    localparam logic [SW-1:0]   TAIL       = SW'(TAIL_SLOT);
    localparam logic [AC_W-1:0] ALLOC_FULL = AC_W'(POOL_NODES);
    localparam logic [AC_W-1:0] ALLOC_INIT = AC_W'(ALLOC_RESET);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIX,
        S_WALK,
        S_PUSH
    } t_state;

    t_state                    r_state, n_state;
    t_mode                     r_mode, n_mode;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic [SW-1:0]             r_cur, n_cur;
    logic [SW-1:0]             r_link, n_link;
    logic [SW-1:0]             r_head_next, n_head_next;
    logic [SW-1:0]             r_tail_prev, n_tail_prev;
    logic [AC_W-1:0]           r_alloc, n_alloc;
    t_status                   r_res_status, n_res_status;
    logic [SW-1:0]             r_res_slot, n_res_slot;
    logic                      r_o_valid, n_o_valid;
    t_status                   r_o_status, n_o_status;
    logic [SLOT_OUT_W-1:0]     r_o_slot, n_o_slot;

    t_mode                     req_mode;
    logic [SW-1:0]             alloc_slot;
    logic [SW-1:0]             rd_addr;
    logic                      nm_we_value;
    logic                      nm_we_next;
    logic [SW-1:0]             nm_waddr;
    logic signed [VALUE_W-1:0] nm_wvalue;
    logic [SW-1:0]             nm_wnext;
    logic signed [VALUE_W-1:0] nm_rvalue;
    logic [SW-1:0]             nm_rnext;
    logic                      pv_we;
    logic [SW-1:0]             pv_waddr;
    logic [SW-1:0]             pv_wdata;
    logic [SW-1:0]             pv_rdata;

    assign req_mode   = t_mode'(i_req.mode);
    assign alloc_slot = r_alloc[SW-1:0];

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_o_valid;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.node_slot = r_o_slot;

    pdll_node_mem #(
        .DEPTH (POOL_NODES)
    ) u_node_mem (
        .i_clk      (i_clk),
        .i_we_value (nm_we_value),
        .i_we_next  (nm_we_next),
        .i_waddr    (nm_waddr),
        .i_wvalue   (nm_wvalue),
        .i_wnext    (nm_wnext),
        .i_raddr    (rd_addr),
        .o_rvalue   (nm_rvalue),
        .o_rnext    (nm_rnext)
    );

    pdll_ram #(
        .WIDTH (SW),
        .DEPTH (POOL_NODES)
    ) u_prev_mem (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_raddr (rd_addr),
        .o_rdata (pv_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_value      = r_value;
        n_cur        = r_cur;
        n_link       = r_link;
        n_head_next  = r_head_next;
        n_tail_prev  = r_tail_prev;
        n_alloc      = r_alloc;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_o_valid    = r_o_valid;
        n_o_status   = r_o_status;
        n_o_slot     = r_o_slot;

        rd_addr     = r_cur;
        nm_we_value = 1'b0;
        nm_we_next  = 1'b0;
        nm_waddr    = r_cur;
        nm_wvalue   = r_value;
        nm_wnext    = TAIL;
        pv_we       = 1'b0;
        pv_waddr    = r_cur;
        pv_wdata    = HEAD;

        if (r_o_valid && o_rsp.ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode  = req_mode;
                    n_value = i_req.value;
                    case (req_mode) inside
                        MODE_INS_HEAD, MODE_INS_TAIL: begin
                            if (r_alloc == ALLOC_FULL) begin
                                n_res_status = ST_FULL;
                                n_res_slot   = '0;
                                n_state      = S_PUSH;
                            end else begin
                                nm_we_value = 1'b1;
                                nm_we_next  = 1'b1;
                                pv_we       = 1'b1;
                                nm_waddr    = alloc_slot;
                                pv_waddr    = alloc_slot;
                                nm_wvalue   = i_req.value;
                                if (req_mode == MODE_INS_HEAD) begin
                                    nm_wnext    = r_head_next;
                                    pv_wdata    = HEAD;
                                    n_link      = r_head_next;
                                    n_head_next = alloc_slot;
                                end else begin
                                    nm_wnext    = TAIL;
                                    pv_wdata    = r_tail_prev;
                                    n_link      = r_tail_prev;
                                    n_tail_prev = alloc_slot;
                                end
                                n_cur   = alloc_slot;
                                n_alloc = r_alloc + AC_W'(1);
                                n_state = S_FIX;
                            end
                        end
                        default: begin
                            if (r_head_next == TAIL) begin
                                n_res_status = ST_NOT_FOUND;
                                n_res_slot   = '0;
                                n_state      = S_PUSH;
                            end else begin
                                rd_addr = r_head_next;
                                n_cur   = r_head_next;
                                n_state = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_FIX: begin
                if (r_mode == MODE_INS_HEAD) begin
                    if (r_link == TAIL) begin
                        n_tail_prev = r_cur;
                    end else begin
                        pv_we    = 1'b1;
                        pv_waddr = r_link;
                        pv_wdata = r_cur;
                    end
                end else begin
                    if (r_link == HEAD) begin
                        n_head_next = r_cur;
                    end else begin
                        nm_we_next = 1'b1;
                        nm_waddr   = r_link;
                        nm_wnext   = r_cur;
                    end
                end
                n_res_status = ST_DONE;
                n_res_slot   = r_cur;
                n_state      = S_PUSH;
            end
            S_WALK: begin
                if (nm_rvalue == r_value) begin
                    n_res_slot = r_cur;
                    n_state    = S_PUSH;
                    if (r_mode == MODE_DELETE) begin
                        n_res_status = ST_DONE;
                        if (nm_rnext == TAIL) begin
                            n_tail_prev = pv_rdata;
                        end else begin
                            pv_we    = 1'b1;
                            pv_waddr = nm_rnext;
                            pv_wdata = pv_rdata;
                        end
                        if (pv_rdata == HEAD) begin
                            n_head_next = nm_rnext;
                        end else begin
                            nm_we_next = 1'b1;
                            nm_waddr   = pv_rdata;
                            nm_wnext   = nm_rnext;
                        end
                    end else begin
                        n_res_status = ST_FOUND;
                    end
                end else if (nm_rnext == TAIL) begin
                    n_res_status = ST_NOT_FOUND;
                    n_res_slot   = '0;
                    n_state      = S_PUSH;
                end else begin
                    rd_addr = nm_rnext;
                    n_cur   = nm_rnext;
                end
            end
            S_PUSH: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_slot   = SLOT_OUT_W'(r_res_slot);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_o_valid   <= 1'b0;
            r_head_next <= TAIL;
            r_tail_prev <= HEAD;
            r_alloc     <= ALLOC_INIT;
        end else begin
            r_state     <= n_state;
            r_o_valid   <= n_o_valid;
            r_head_next <= n_head_next;
            r_tail_prev <= n_tail_prev;
            r_alloc     <= n_alloc;
        end
        r_mode       <= n_mode;
        r_value      <= n_value;
        r_cur        <= n_cur;
        r_link       <= n_link;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_o_status   <= n_o_status;
        r_o_slot     <= n_o_slot;
    end

endmodule

`default_nettype wire

/* hw/rtl/pdll_chk.sv */
// Port-level checker for the pooled doubly linked list, bound to the top.
// Depends on pdll_pkg and pooled_doubly_linked_list_defines.svh.
`default_nettype none
`include "pooled_doubly_linked_list_defines.svh"

module pdll_chk (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_req_valid,
    input wire logic                                i_req_ready,
    input wire logic                                i_rsp_valid,
    input wire logic                                i_rsp_ready,
    input wire logic [pdll_pkg::STATUS_W-1:0]       i_rsp_status,
    input wire logic [pdll_pkg::SLOT_OUT_W-1:0]     i_rsp_slot
);
    import pdll_pkg::*;

    // No result word may appear straight out of reset.
    `PDLL_ASSERT_CLK(a_rst_no_rsp, i_clk, !i_rst_n |=> !i_rsp_valid)

    // A request is worked on alone, so the input closes after each word.
    `PDLL_ASSERT_RST(a_one_at_a_time, i_clk, i_rst_n, (i_req_valid && i_req_ready) |=> !i_req_ready)

    // Pool full and not found carry no slot.
    `PDLL_ASSERT_RST(a_no_slot, i_clk, i_rst_n, (i_rsp_valid && (i_rsp_status == ST_FULL || i_rsp_status == ST_NOT_FOUND)) |-> (i_rsp_slot == '0))

    // A stalled result word holds.
    `PDLL_ASSERT_RST(a_rsp_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_slot)))

endmodule

bind pooled_doubly_linked_list pdll_chk u_pdll_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_slot   (o_rsp.node_slot)
);

`default_nettype wire
